// ===== rtl/mgwa_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the marker to grid deposition block
// no dependencies

package mgwa_pkg;

	localparam int DATA_W      = 32;
	localparam int IDX_W       = 12;
	localparam int CFG_IDX_W   = 8;
	localparam int COUNT_REG_W = 7;
	localparam int SPACING_W   = 31;
	localparam int SUM_W       = 64;

	// register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_COLS   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_W = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_H = 8'd3;

	localparam logic [COUNT_REG_W-1:0] COUNT_RESET   = 7'd64;
	localparam logic [SPACING_W-1:0]   SPACING_RESET = 31'd65536;

	// action field codes
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_0000;
	localparam logic [DATA_W-1:0] VALUE_MAX   = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] VALUE_MIN   = 32'h8000_0000;
	localparam logic [DATA_W-1:0] WEIGHT_MAX  = 32'hFFFF_FFFF;

	// weight is the doubled-distance product shifted down by this much
	localparam int WEIGHT_FRAC = 18;
	localparam int WEIGHT_TOP  = WEIGHT_FRAC + DATA_W;

	typedef enum logic [1:0] {
		JOB_ADD,
		JOB_READ,
		JOB_MISS
	} job_kind_t;

	typedef struct packed {
		job_kind_t               kind;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         idx;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} queue_head_t;

	typedef struct packed {
		logic pop;
		logic accepting;
	} back_status_t;

endpackage

// ===== rtl/mgwa_if.sv =====
`timescale 1ns / 1ps
// channel interfaces: marker items, cell results, configuration writes
// depends on mgwa_pkg

interface mgwa_item_if import mgwa_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic signed [DATA_W-1:0] marker_x;
	logic signed [DATA_W-1:0] marker_y;
	logic signed [DATA_W-1:0] marker_value;
	logic [IDX_W-1:0]         cell_index;

	modport source (output valid, action, marker_x, marker_y, marker_value, cell_index,
		input ready);
	modport sink (input valid, action, marker_x, marker_y, marker_value, cell_index,
		output ready);
endinterface

interface mgwa_result_if import mgwa_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] cell_value;
	logic                     cell_empty;

	modport source (output valid, cell_value, cell_empty, input ready);
	modport sink (input valid, cell_value, cell_empty, output ready);
endinterface

interface mgwa_cfg_if import mgwa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mgwa_front.sv =====
`timescale 1ns / 1ps
// front end: accepts items, classifies them and holds them in a two entry queue
// depends on mgwa_pkg and mgwa_if

module mgwa_front import mgwa_pkg::*; #(
	parameter int CELLS = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	mgwa_item_if.sink     item,
	input  back_status_t  status,
	output queue_head_t   head
);

	job_t       slot_q [2];
	logic [1:0] count_q;
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic       push;
	logic       pop;
	job_t       job_in;

	assign item.ready = (count_q != 2'd2) && status.accepting;
	assign push       = item.valid && item.ready;
	assign pop        = status.pop && (count_q != 2'd0);

	always_comb begin
		job_in.x     = item.marker_x;
		job_in.y     = item.marker_y;
		job_in.value = item.marker_value;
		job_in.idx   = item.cell_index;
		if (item.action == ACT_ADD) begin
			job_in.kind = JOB_ADD;
		end else if (32'(item.cell_index) < CELLS) begin
			job_in.kind = JOB_READ;
		end else begin
			// index beyond the store: empty result, no state change
			job_in.kind = JOB_MISS;
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= job_in;
		end
	end

endmodule

// ===== rtl/mgwa_locate.sv =====
`timescale 1ns / 1ps
// node index and doubled distance to the cell center along one axis
// depends on mgwa_pkg; restoring division, one quotient bit per cycle

module mgwa_locate import mgwa_pkg::*; #(
	parameter int MAXN = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [DATA_W-1:0]    pos,
	input  logic [SPACING_W-1:0]        spacing,
	input  logic [$clog2(MAXN):0]       count,
	output logic                        idle,
	output logic [$clog2(MAXN)-1:0]     index,
	output logic [$clog2(MAXN)+32:0]    dist2
);

	localparam int QW = $clog2(MAXN);
	localparam int NW = QW + 1;
	localparam int LW = QW + 33;
	localparam int CW = QW + 34;
	localparam int SW = (QW > 1) ? $clog2(QW) : 1;

	typedef enum logic [1:0] {
		L_IDLE,
		L_CHK,
		L_DIV,
		L_DIST
	} lstate_t;

	lstate_t                  state_q;
	logic signed [DATA_W-1:0] pos_q;
	logic [SPACING_W-1:0]     d_q;
	logic [NW-1:0]            cnt_q;
	logic signed [33:0]       n_q;
	logic [LW-1:0]            lim_q;
	logic [LW-1:0]            r_q;
	logic [LW-1:0]            dv_q;
	logic [QW-1:0]            q_q;
	logic [SW-1:0]            step_q;
	logic [LW-1:0]            dist_q;

	logic signed [33:0]       n_in;
	logic [LW-1:0]            lim_in;
	logic [LW-1:0]            n_ext;
	logic                     sub_ok;
	logic [QW+31:0]           mul_m;
	logic signed [CW-1:0]     c;
	logic [CW-1:0]            c_abs;

	// numerator 2x+dx, limit count*2dx beyond which the index clamps
	assign n_in   = $signed({pos[31], pos, 1'b0}) + $signed({3'b000, spacing});
	assign lim_in = count * {spacing, 1'b0};
	assign n_ext  = LW'(n_q[32:0]);
	assign sub_ok = (r_q >= dv_q);

	// signed distance 2x - (2q+1)dx
	assign mul_m = {q_q, 1'b1} * d_q;
	assign c     = CW'($signed({pos_q, 1'b0})) - $signed({2'b00, mul_m});
	assign c_abs = c[CW-1] ? CW'(-c) : CW'(c);

	assign idle  = (state_q == L_IDLE);
	assign index = q_q;
	assign dist2 = dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			pos_q   <= '0;
			d_q     <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
			lim_q   <= '0;
			r_q     <= '0;
			dv_q    <= '0;
			q_q     <= '0;
			step_q  <= '0;
			dist_q  <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (start) begin
						pos_q   <= pos;
						d_q     <= spacing;
						cnt_q   <= count;
						n_q     <= n_in;
						lim_q   <= lim_in;
						state_q <= L_CHK;
					end
				end
				L_CHK: begin
					if ((d_q == '0) || n_q[33]) begin
						// zero spacing or left of the grid
						q_q     <= '0;
						state_q <= L_DIST;
					end else if (n_ext >= lim_q) begin
						q_q     <= QW'(cnt_q - NW'(1));
						state_q <= L_DIST;
					end else begin
						r_q     <= n_ext;
						dv_q    <= LW'({d_q, 1'b0}) << (QW - 1);
						q_q     <= '0;
						step_q  <= '0;
						state_q <= L_DIV;
					end
				end
				L_DIV: begin
					if (sub_ok) begin
						r_q <= r_q - dv_q;
					end
					dv_q   <= dv_q >> 1;
					q_q    <= QW'({q_q, sub_ok});
					step_q <= step_q + SW'(1);
					if (step_q == SW'(QW - 1)) begin
						state_q <= L_DIST;
					end
				end
				L_DIST: begin
					dist_q  <= c_abs[LW-1:0];
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/mgwa_div.sv =====
`timescale 1ns / 1ps
// unsigned 64 by 64 division with a 32 bit quotient and an overflow flag
// depends on mgwa_pkg; one quotient bit per cycle

module mgwa_div import mgwa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [SUM_W-1:0]  divisor,
	output logic              idle,
	output logic [DATA_W-1:0] quotient,
	output logic              big
);

	typedef enum logic {
		D_IDLE,
		D_RUN
	} dstate_t;

	dstate_t           state_q;
	logic [SUM_W-1:0]  r_q;
	logic [SUM_W-1:0]  dv_q;
	logic [DATA_W-1:0] lo_q;
	logic [DATA_W-1:0] quo_q;
	logic [4:0]        cnt_q;
	logic              big_q;
	logic [SUM_W:0]    t;
	logic              ge;

	assign t  = {r_q, lo_q[DATA_W-1]};
	assign ge = (t >= {1'b0, dv_q});

	assign idle     = (state_q == D_IDLE);
	assign quotient = quo_q;
	assign big      = big_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			r_q     <= '0;
			dv_q    <= '0;
			lo_q    <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			big_q   <= 1'b0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						// quotient of 2^32 or more only needs the flag
						big_q <= ({32'd0, dividend[63:32]} >= divisor);
						r_q   <= {32'd0, dividend[63:32]};
						lo_q  <= dividend[31:0];
						dv_q  <= divisor;
						quo_q <= '0;
						cnt_q <= '0;
						if ({32'd0, dividend[63:32]} < divisor) begin
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					r_q   <= ge ? SUM_W'(t - {1'b0, dv_q}) : t[SUM_W-1:0];
					lo_q  <= {lo_q[DATA_W-2:0], 1'b0};
					quo_q <= {quo_q[DATA_W-2:0], ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/mgwa_back.sv =====
`timescale 1ns / 1ps
// back end: per-cell accumulation stores, weight arithmetic and cell reads
// depends on mgwa_pkg, mgwa_if, mgwa_locate and mgwa_div

module mgwa_back import mgwa_pkg::*; #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  queue_head_t               head,
	output back_status_t              status,
	input  logic [$clog2(MAX_COLS):0] cols,
	input  logic [$clog2(MAX_ROWS):0] rows,
	input  logic [SPACING_W-1:0]      cell_width,
	input  logic [SPACING_W-1:0]      cell_height,
	mgwa_result_if.source             result
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int CIW   = $clog2(CELLS);
	localparam int QWC   = $clog2(MAX_COLS);
	localparam int QWR   = $clog2(MAX_ROWS);
	localparam int AWC   = QWC + 33;
	localparam int AWR   = QWR + 33;
	localparam int PW    = AWC + AWR;
	localparam int HL    = (AWR + 1) / 2;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_LOC,
		S_MH,
		S_SAT,
		S_VW,
		S_WR,
		S_RWAIT,
		S_RCHK,
		S_DIVW,
		S_RES
	} bstate_t;

	bstate_t                  state_q;
	logic [CIW-1:0]           init_q;
	logic [CIW-1:0]           addr_q;
	logic signed [DATA_W-1:0] val_q;
	logic [PW-1:0]            pp_q;
	logic [DATA_W-1:0]        w_q;
	logic [SUM_W-1:0]         vw_q;
	logic                     neg_q;
	logic [DATA_W-1:0]        res_q;
	logic                     empty_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_value_q;
	logic                     out_empty_q;

	logic [SUM_W-1:0]         ws_mem [CELLS];
	logic [SUM_W-1:0]         wt_mem [CELLS];
	logic [SUM_W-1:0]         rd_ws_q;
	logic [SUM_W-1:0]         rd_wt_q;

	logic                     mem_we;
	logic [CIW-1:0]           mem_waddr;
	logic [SUM_W-1:0]         ws_wdata;
	logic [SUM_W-1:0]         wt_wdata;

	logic                     loc_start;
	logic                     locx_idle;
	logic                     locy_idle;
	logic [QWC-1:0]           col_idx;
	logic [QWR-1:0]           row_idx;
	logic [AWC-1:0]           ax;
	logic [AWR-1:0]           ay;

	logic [HL-1:0]            mul_b;
	logic [AWC+HL-1:0]        mul_p;
	logic [CIW-1:0]           cell_addr;
	logic [DATA_W-1:0]        w_sat;
	logic signed [SUM_W:0]    vw_full;
	logic [SUM_W:0]           ws_sum;
	logic [SUM_W-1:0]         ws_new;
	logic [SUM_W:0]           wt_sum;
	logic [SUM_W-1:0]         wt_new;
	logic [SUM_W-1:0]         mag;
	logic                     div_start;
	logic                     div_idle;
	logic [DATA_W-1:0]        div_quo;
	logic                     div_big;
	logic [DATA_W-1:0]        avg;
	logic                     out_load;

	assign status.pop       = (state_q == S_IDLE) && head.valid;
	assign status.accepting = (state_q != S_INIT);

	assign loc_start = status.pop && (head.job.kind == JOB_ADD);

	mgwa_locate #(.MAXN(MAX_COLS)) u_loc_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (loc_start),
		.pos     (head.job.x),
		.spacing (cell_width),
		.count   (cols),
		.idle    (locx_idle),
		.index   (col_idx),
		.dist2   (ax)
	);

	mgwa_locate #(.MAXN(MAX_ROWS)) u_loc_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (loc_start),
		.pos     (head.job.y),
		.spacing (cell_height),
		.count   (rows),
		.idle    (locy_idle),
		.index   (row_idx),
		.dist2   (ay)
	);

	// distance product in two halves on one multiplier
	assign mul_b     = (state_q == S_LOC) ? ay[HL-1:0] : HL'(ay[AWR-1:HL]);
	assign mul_p     = ax * mul_b;
	assign cell_addr = CIW'(32'(row_idx) + 32'(rows) * 32'(col_idx));
	assign w_sat = (|pp_q[PW-1:WEIGHT_TOP]) ? WEIGHT_MAX : pp_q[WEIGHT_TOP-1:WEIGHT_FRAC];

	assign vw_full = $signed(val_q) * $signed({1'b0, w_q});

	// saturating accumulation
	assign ws_sum = {rd_ws_q[SUM_W-1], rd_ws_q} + {vw_q[SUM_W-1], vw_q};
	assign ws_new = (ws_sum[SUM_W] != ws_sum[SUM_W-1]) ?
		(ws_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}}) :
		ws_sum[SUM_W-1:0];
	assign wt_sum = {1'b0, rd_wt_q} + {33'd0, w_q};
	assign wt_new = wt_sum[SUM_W] ? {SUM_W{1'b1}} : wt_sum[SUM_W-1:0];

	assign mag       = rd_ws_q[SUM_W-1] ? (64'd0 - rd_ws_q) : rd_ws_q;
	assign div_start = (state_q == S_RCHK) && (rd_wt_q != '0);

	mgwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (rd_wt_q),
		.idle     (div_idle),
		.quotient (div_quo),
		.big      (div_big)
	);

	always_comb begin
		if (neg_q) begin
			avg = (div_big || (div_quo > VALUE_MIN)) ? VALUE_MIN : (32'd0 - div_quo);
		end else begin
			avg = (div_big || div_quo[DATA_W-1]) ? VALUE_MAX : div_quo;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		ws_wdata  = '0;
		wt_wdata  = '0;
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = init_q;
			end
			S_WR: begin
				mem_we   = 1'b1;
				ws_wdata = ws_new;
				wt_wdata = wt_new;
			end
			S_RCHK: mem_we = 1'b1;
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ws_mem[mem_waddr] <= ws_wdata;
			wt_mem[mem_waddr] <= wt_wdata;
		end
		rd_ws_q <= ws_mem[addr_q];
		rd_wt_q <= wt_mem[addr_q];
	end

	assign out_load = (state_q == S_RES) && (!out_valid_q || result.ready);

	assign result.valid      = out_valid_q;
	assign result.cell_value = out_value_q;
	assign result.cell_empty = out_empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			addr_q      <= '0;
			val_q       <= '0;
			pp_q        <= '0;
			w_q         <= '0;
			vw_q        <= '0;
			neg_q       <= 1'b0;
			res_q       <= '0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_empty_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_value_q <= res_q;
				out_empty_q <= empty_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_q <= init_q + CIW'(1);
					if (init_q == CIW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (head.valid) begin
						case (head.job.kind)
							JOB_ADD: begin
								val_q   <= head.job.value;
								state_q <= S_LOC;
							end
							JOB_READ: begin
								addr_q  <= CIW'(head.job.idx);
								state_q <= S_RWAIT;
							end
							default: begin
								res_q   <= EMPTY_VALUE;
								empty_q <= 1'b1;
								state_q <= S_RES;
							end
						endcase
					end
				end
				S_LOC: begin
					if (locx_idle && locy_idle) begin
						addr_q  <= cell_addr;
						pp_q    <= PW'(mul_p);
						state_q <= S_MH;
					end
				end
				S_MH: begin
					pp_q    <= pp_q + (PW'(mul_p) << HL);
					state_q <= S_SAT;
				end
				S_SAT: begin
					w_q     <= w_sat;
					state_q <= S_VW;
				end
				S_VW: begin
					vw_q    <= vw_full[SUM_W-1:0];
					state_q <= S_WR;
				end
				S_WR: state_q <= S_IDLE;
				S_RWAIT: state_q <= S_RCHK;
				S_RCHK: begin
					neg_q <= rd_ws_q[SUM_W-1];
					if (rd_wt_q == '0) begin
						res_q   <= EMPTY_VALUE;
						empty_q <= 1'b1;
						state_q <= S_RES;
					end else begin
						state_q <= S_DIVW;
					end
				end
				S_DIVW: begin
					if (div_idle) begin
						res_q   <= avg;
						empty_q <= 1'b0;
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/marker_to_grid_weighted_average.sv =====
`timescale 1ns / 1ps
// marker to grid deposition, top level: configuration registers, front queue, back end
// add: the back end runs the division loop of the locators, then weights and accumulates
// read: the average comes from the one bit per cycle divider
// one item at a time in the back end; the front queue keeps taking up to two items meanwhile
// after reset a clearing pass over all MAX_COLS*MAX_ROWS cells runs before items are taken;
// configuration writes are taken at any time, registers reset to 64 x 64 cells of 1.0

module marker_to_grid_weighted_average import mgwa_pkg::*; #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	mgwa_item_if.sink     item,
	mgwa_result_if.source result,
	mgwa_cfg_if.sink      cfg
);

	localparam int NWC = $clog2(MAX_COLS) + 1;
	localparam int NWR = $clog2(MAX_ROWS) + 1;

	// configuration registers
	logic [COUNT_REG_W-1:0] cols_in_use_q;
	logic [COUNT_REG_W-1:0] rows_in_use_q;
	logic [SPACING_W-1:0]   cell_width_q;
	logic [SPACING_W-1:0]   cell_height_q;

	logic [NWC-1:0]         cols;
	logic [NWR-1:0]         rows;
	queue_head_t            head;
	back_status_t           status;

	// config channel never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_in_use_q <= COUNT_RESET;
			rows_in_use_q <= COUNT_RESET;
			cell_width_q  <= SPACING_RESET;
			cell_height_q <= SPACING_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_COLS:   cols_in_use_q <= cfg.data[COUNT_REG_W-1:0];
				REG_ROWS:   rows_in_use_q <= cfg.data[COUNT_REG_W-1:0];
				REG_CELL_W: cell_width_q  <= cfg.data[SPACING_W-1:0];
				REG_CELL_H: cell_height_q <= cfg.data[SPACING_W-1:0];
				default:    cell_height_q <= cell_height_q;
			endcase
		end
	end

	// grid size clamped to the store: at least two, at most the maximum
	always_comb begin
		if (cols_in_use_q < 7'd2) begin
			cols = NWC'(2);
		end else if (32'(cols_in_use_q) > MAX_COLS) begin
			cols = NWC'(MAX_COLS);
		end else begin
			cols = NWC'(cols_in_use_q);
		end
		if (rows_in_use_q < 7'd2) begin
			rows = NWR'(2);
		end else if (32'(rows_in_use_q) > MAX_ROWS) begin
			rows = NWR'(MAX_ROWS);
		end else begin
			rows = NWR'(rows_in_use_q);
		end
	end

	// front: transfer acceptance, classification, two entry queue
	mgwa_front #(.CELLS(MAX_COLS * MAX_ROWS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.status (status),
		.head   (head)
	);

	// back: locate, weight, accumulate or read and clear, output register
	mgwa_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.status      (status),
		.cols        (cols),
		.rows        (rows),
		.cell_width  (cell_width_q),
		.cell_height (cell_height_q),
		.result      (result)
	);

endmodule

// ===== tb/sv/marker_to_grid_weighted_average_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the marker to grid deposition block
// depends on mgwa_pkg, the channel interfaces and the block's top level

module marker_to_grid_weighted_average_tb;
	import mgwa_pkg::*;

	typedef struct {
		logic                     action;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] value;
		logic [IDX_W-1:0]         idx;
	} marker_item_t;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              empty;
	} cell_result_t;

	localparam int CELLS = 64 * 64;

	logic clk;
	logic arst_n;

	mgwa_item_if   item ();
	mgwa_result_if result ();
	mgwa_cfg_if    cfg ();

	marker_to_grid_weighted_average dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	// predictor state: its own copy of the registers and both per-cell stores
	logic [COUNT_REG_W-1:0] grid_cols;
	logic [COUNT_REG_W-1:0] grid_rows;
	logic [SPACING_W-1:0]   spacing_x;
	logic [SPACING_W-1:0]   spacing_y;
	longint                 weighted_sum_store [CELLS];
	longint unsigned        weight_store [CELLS];

	marker_item_t pending_markers [$];
	cell_result_t expected_cells [$];
	int           fail_count;
	logic         marker_taken;
	int           send_gap;
	int           recv_stall;
	logic         no_idle;

	// free running clock, 12 ns period
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// grid size as the block uses it, clamped to 2..64
	function automatic longint used_count(input logic [COUNT_REG_W-1:0] n);
		if (n < 2)
			return 2;
		if (n > 64)
			return 64;
		return n;
	endfunction

	// nearest node along one axis and the doubled distance to the cell center
	function automatic longint find_node(input longint pos, input longint spacing,
		input longint count, output longint unsigned dist2);
		longint q;
		longint c;
		q = 0;
		if (spacing != 0)
			q = (2 * pos + spacing) / (2 * spacing);
		if (q < 0)
			q = 0;
		if (q > count - 1)
			q = count - 1;
		c = 2 * pos - (2 * q + 1) * spacing;
		dist2 = (c < 0) ? longint'(-c) : longint'(c);
		return q;
	endfunction

	// add: accumulate value times weight and the weight, both saturating
	function automatic void deposit_marker(input marker_item_t m);
		longint unsigned ax, ay, w, lim;
		longint          col, row, cell_addr, prod, sum;
		logic [64:0]     wsum;
		lim = 64'h0003_FFFF_FFFF_FFFF;
		col = find_node(longint'(m.x), longint'(spacing_x), used_count(grid_cols), ax);
		row = find_node(longint'(m.y), longint'(spacing_y), used_count(grid_rows), ay);
		if (ax != 0 && ay > lim / ax)
			w = WEIGHT_MAX;
		else
			w = (ax * ay) >> WEIGHT_FRAC;
		cell_addr = row + used_count(grid_rows) * col;
		if (cell_addr >= CELLS)
			return;
		prod = longint'(m.value) * longint'(w);
		sum = weighted_sum_store[cell_addr] + prod;
		if (weighted_sum_store[cell_addr][63] == prod[63] && sum[63] != prod[63])
			sum = prod[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		weighted_sum_store[cell_addr] = sum;
		wsum = {1'b0, weight_store[cell_addr]} + {1'b0, w};
		weight_store[cell_addr] = wsum[64] ? '1 : wsum[63:0];
	endfunction

	// read: weighted average truncated toward zero, then the cell is cleared
	function automatic cell_result_t read_cell_average(input logic [IDX_W-1:0] idx);
		cell_result_t    r;
		longint          s;
		longint unsigned mag, q;
		r.value = EMPTY_VALUE;
		r.empty = 1'b1;
		if (weight_store[idx] != 0) begin
			s = weighted_sum_store[idx];
			mag = (s < 0) ? (64'd0 - longint'(s)) : longint'(s);
			q = mag / weight_store[idx];
			if (s < 0)
				r.value = (q > 64'h8000_0000) ? VALUE_MIN : DATA_W'(64'd0 - q);
			else
				r.value = (q > 64'h7FFF_FFFF) ? VALUE_MAX : q[DATA_W-1:0];
			r.empty = 1'b0;
		end
		weighted_sum_store[idx] = 0;
		weight_store[idx] = 0;
		return r;
	endfunction

	// item driver: inputs change on the falling edge, one item per transfer
	always @(negedge clk) begin
		if (!arst_n || (item.valid && !marker_taken)) begin
			// hold the current item until its transfer
		end else if (send_gap > 0) begin
			item.valid = 1'b0;
			send_gap = send_gap - 1;
		end else if (pending_markers.size() > 0) begin
			marker_item_t m;
			m = pending_markers.pop_front();
			item.action = m.action;
			item.marker_x = m.x;
			item.marker_y = m.y;
			item.marker_value = m.value;
			item.cell_index = m.idx;
			item.valid = 1'b1;
			send_gap = no_idle ? 0 : $urandom_range(0, 7);
		end else begin
			item.valid = 1'b0;
		end
		marker_taken = 1'b0;
	end

	// result receiver side: random stall per result
	always @(negedge clk) begin
		if (recv_stall > 0) begin
			result.ready = 1'b0;
			recv_stall = recv_stall - 1;
		end else begin
			result.ready = 1'b1;
		end
	end

	// input transfers feed the predictor at the rising edge
	always @(posedge clk) begin
		if (arst_n && item.valid && item.ready) begin
			marker_item_t m;
			m.action = item.action;
			m.x = item.marker_x;
			m.y = item.marker_y;
			m.value = item.marker_value;
			m.idx = item.cell_index;
			marker_taken = 1'b1;
			if (m.action == ACT_ADD)
				deposit_marker(m);
			else
				expected_cells.push_back(read_cell_average(m.idx));
		end
	end

	// result monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			cell_result_t e;
			if (expected_cells.size() == 0) begin
				$error("cell result with nothing expected: value %h empty %b",
					result.cell_value, result.cell_empty);
				fail_count = fail_count + 1;
			end else begin
				e = expected_cells.pop_front();
				if (result.cell_value !== e.value) begin
					$error("cell_value: expected %h actual %h", e.value, result.cell_value);
					fail_count = fail_count + 1;
				end
				if (result.cell_empty !== e.empty) begin
					$error("cell_empty: expected %b actual %b", e.empty, result.cell_empty);
					fail_count = fail_count + 1;
				end
			end
			recv_stall = no_idle ? 0 : $urandom_range(0, 7);
		end
	end

	// one register write over the configuration channel
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg.index = index;
		cfg.data = data;
		cfg.valid = 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (index)
			REG_COLS:   grid_cols = data[COUNT_REG_W-1:0];
			REG_ROWS:   grid_rows = data[COUNT_REG_W-1:0];
			REG_CELL_W: spacing_x = data[SPACING_W-1:0];
			REG_CELL_H: spacing_y = data[SPACING_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// wait until every item is sent and every result has come, then let adds drain
	task automatic wait_idle();
		while (pending_markers.size() > 0 || item.valid || expected_cells.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic queue_add(input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
		input logic signed [DATA_W-1:0] value);
		marker_item_t m;
		m.action = ACT_ADD;
		m.x = x;
		m.y = y;
		m.value = value;
		m.idx = IDX_W'($urandom);
		pending_markers.push_back(m);
	endtask

	task automatic queue_read(input logic [IDX_W-1:0] idx);
		marker_item_t m;
		m.action = ACT_READ;
		m.x = $urandom;
		m.y = $urandom;
		m.value = $urandom;
		m.idx = idx;
		pending_markers.push_back(m);
	endtask

	// position mostly inside the grid domain, sometimes anywhere
	function automatic logic signed [DATA_W-1:0] pick_pos(input longint spacing,
		input longint count);
		longint span, p;
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		span = spacing * count;
		p = longint'({$urandom, $urandom} % (span + 1)) - spacing / 2;
		if (p > 64'sh7FFF_FFFF)
			p = 64'sh7FFF_FFFF;
		return p[DATA_W-1:0];
	endfunction

	task automatic queue_random(input int count);
		longint cols, rows;
		logic signed [DATA_W-1:0] v;
		cols = used_count(grid_cols);
		rows = used_count(grid_rows);
		repeat (count) begin
			if ($urandom_range(0, 9) < 3) begin
				if ($urandom_range(0, 4) < 3)
					queue_read(IDX_W'($urandom_range(0, 63) % rows
						+ rows * ($urandom_range(0, 63) % cols)));
				else
					queue_read(IDX_W'($urandom));
			end else begin
				v = ($urandom_range(0, 1) == 0) ? $urandom : $signed(32'($urandom_range(0, 1 << 20)))
					- (1 << 19);
				queue_add(pick_pos(longint'(spacing_x), cols),
					pick_pos(longint'(spacing_y), rows), v);
			end
		end
	endtask

	task automatic run_phase(input logic [DATA_W-1:0] cols, input logic [DATA_W-1:0] rows,
		input logic [DATA_W-1:0] dx, input logic [DATA_W-1:0] dy, input int count);
		wait_idle();
		write_reg(REG_COLS, cols);
		write_reg(REG_ROWS, rows);
		write_reg(REG_CELL_W, dx);
		write_reg(REG_CELL_H, dy);
		// first half with random idling, second half back to back
		no_idle = 1'b0;
		queue_random(count / 2);
		while (pending_markers.size() > 0)
			@(posedge clk);
		no_idle = 1'b1;
		queue_random(count - count / 2);
		while (pending_markers.size() > 0)
			@(posedge clk);
		no_idle = 1'b0;
	endtask

	// stimulus and end of run
	initial begin
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.action = ACT_ADD;
		item.marker_x = '0;
		item.marker_y = '0;
		item.marker_value = '0;
		item.cell_index = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_COLS;
		cfg.data = '0;
		fail_count = 0;
		marker_taken = 1'b0;
		send_gap = 0;
		recv_stall = 0;
		no_idle = 1'b0;
		grid_cols = COUNT_RESET;
		grid_rows = COUNT_RESET;
		spacing_x = SPACING_RESET;
		spacing_y = SPACING_RESET;
		for (int i = 0; i < CELLS; i++) begin
			weighted_sum_store[i] = 0;
			weight_store[i] = 0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part on the reset grid of 64 x 64 unit cells
		queue_add(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF); // corner, weight saturates
		queue_add(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF); // sum saturates high
		queue_read(12'd63);
		queue_add(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
		queue_add(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000); // sum saturates low
		queue_read(12'd4032);
		queue_add(32'sh0000_8000, 32'sh0001_8000, 32'sh0001_0000); // lands in cell 66, weight nonzero
		queue_read(12'd1);
		queue_add(32'sh0000_4000, 32'sh0000_4000, 32'sh0003_0000);
		queue_add(32'sh0000_6000, 32'sh0000_2000, 32'shFFFE_0000);
		queue_add(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0001);
		queue_read(12'd0);
		queue_read(12'd0);                                         // cleared cell reads empty
		queue_add(32'sh003F_C000, 32'sh003F_C000, 32'sh0000_0000);
		queue_read(12'd4095);
		queue_read(12'd2000);                                      // never touched
		queue_add(32'shFFFF_0000, 32'sh0002_0000, 32'sh7FFF_FFFF); // negative x clamps to column 0
		queue_read(12'd2);
		while (pending_markers.size() > 0)
			@(posedge clk);

		// upper register bits are dropped, so these also test masking
		run_phase(32'hFFFF_FF82, 32'h0000_0002, 32'h0000_0001, 32'h0000_0001, 160);
		run_phase(32'h0000_007F, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 160);
		run_phase(32'h0000_0001, 32'h0000_0040, 32'h0000_0000, 32'h7FFF_FFFF, 140);
		run_phase(32'h0000_0008, 32'h0000_0005, 32'h0000_4000, 32'h0002_8000, 160);
		run_phase(32'($urandom_range(2, 64)), 32'($urandom_range(2, 64)),
			32'($urandom_range(1, 32'h0004_0000)), 32'($urandom_range(1, 32'h0004_0000)), 160);
		wait_idle();

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
